// ===== hw/rtl/fssc_pkg.sv =====
// Package for the flywheel speed step controller.
// Holds shared widths, constants, register indexes, the controller state type
// and the configuration, command and status structs. It depends on nothing else.
package fssc_pkg;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_TARGET_SPEED    = 3'd0;
	localparam logic [2:0] REG_MAX_ERROR       = 3'd1;
	localparam logic [2:0] REG_BATTERY_DIVISOR = 3'd2;
	localparam logic [2:0] REG_BATTERY_GAIN    = 3'd3;
	localparam logic [2:0] REG_ERROR_DIVISOR   = 3'd4;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 10;

	// Shared restoring divider: 14-bit dividend, 10-bit divisor
	localparam int DVD_W     = 14;
	localparam int DVS_W     = 10;
	localparam int DIV_STEPS = 14;
	localparam int STEP_W    = 4;

	// Drive level is signed Q8.8
	localparam int LEVEL_W = 17;
	localparam logic signed [LEVEL_W-1:0] DRIVE_MAX_Q = 17'sd32512;
	localparam logic signed [16:0]        DRIVE_MAX   = 17'sd127;
	localparam logic signed [9:0]         RAMP_GAIN_Q = 10'sd307;

	// Error bands
	localparam logic [13:0] RAMP_THRESHOLD = 14'd75;
	localparam logic [13:0] HIGH_THRESHOLD = 14'd3;
	localparam logic [6:0]  ADD_HIGH = 7'd80;
	localparam logic [6:0]  ADD_MID  = 7'd40;
	localparam logic [6:0]  ADD_ZERO = 7'd15;
	localparam logic [6:0]  ADD_NEG  = 7'd0;

	typedef struct packed {
		logic [7:0] target_speed;
		logic [9:0] max_error;
		logic [9:0] battery_divisor;
		logic [7:0] battery_gain;
		logic [3:0] error_divisor;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BAT_DIV,
		ST_ERR_LOAD,
		ST_ERR_DIV,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic load_err;
		logic update;
	} cmd_t;

	typedef struct packed {
		logic div_last;
		logic out_free;
	} sts_t;

endpackage

// ===== hw/rtl/fssc_regs.sv =====
// Configuration registers of the flywheel speed step controller.
// Depends on fssc_pkg for the register indexes and the cfg_t struct.
module fssc_regs
	import fssc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_speed    <= 8'd0;
			cfg_q.max_error       <= 10'd0;
			cfg_q.battery_divisor <= 10'd1;
			cfg_q.battery_gain    <= 8'd0;
			cfg_q.error_divisor   <= 4'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TARGET_SPEED:    cfg_q.target_speed    <= cfg_data[7:0];
				REG_MAX_ERROR:       cfg_q.max_error       <= cfg_data;
				REG_BATTERY_DIVISOR: cfg_q.battery_divisor <= cfg_data;
				REG_BATTERY_GAIN:    cfg_q.battery_gain    <= cfg_data[7:0];
				REG_ERROR_DIVISOR:   cfg_q.error_divisor   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/fssc_ctrl.sv =====
// Controller state machine of the flywheel speed step controller.
// Depends on fssc_pkg for state_t, cmd_t and sts_t.
module fssc_ctrl
	import fssc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_BAT_DIV;
			ST_BAT_DIV:  if (sts.div_last) state_d = ST_ERR_LOAD;
			ST_ERR_LOAD: state_d = ST_ERR_DIV;
			ST_ERR_DIV:  if (sts.div_last) state_d = ST_UPDATE;
			ST_UPDATE:   if (sts.out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_BAT_DIV:  cmd.step     = 1'b1;
			ST_ERR_LOAD: cmd.load_err = 1'b1;
			ST_ERR_DIV:  cmd.step     = 1'b1;
			ST_UPDATE:   cmd.update   = sts.out_free;
			default: ;
		endcase
	end

endmodule

// ===== hw/rtl/fssc_datapath.sv =====
// Datapath of the flywheel speed step controller: shared restoring divider,
// compensation multiplier, band selection, drive level and output register.
// Depends on fssc_pkg for widths, constants and the command and status structs.
module fssc_datapath
	import fssc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic signed [11:0] encoder_count,
	input  logic [13:0]        battery_level,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [7:0]  drive
);

	logic [DVS_W-1:0]  rem_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [STEP_W-1:0] step_q;
	logic              diff_neg_q;
	logic [11:0]       diff_mag_q;
	logic signed [23:0] prod_q;
	logic signed [LEVEL_W-1:0] level_q;
	logic signed [7:0] drive_q;
	logic              out_valid_q;

	logic signed [12:0] diff;
	logic [12:0]        diff_abs;
	logic [DVS_W-1:0]   bat_dvs;
	logic [DVS_W-1:0]   err_dvs;
	logic [DVS_W:0]     rem_sh;
	logic [DVS_W:0]     rem_sub;
	logic               q_bit;
	logic signed [16:0] comp_diff;
	logic signed [25:0] comp_prod;
	logic signed [23:0] prod_adj;
	logic signed [15:0] base;
	logic               err_neg;
	logic               ramp_sel;
	logic [6:0]         band_add;
	logic signed [16:0] band_sum;
	logic signed [7:0]  band_clamp;
	logic signed [17:0] ramp_in;
	logic signed [27:0] ramp_prod;
	logic signed [27:0] ramp_adj;
	logic signed [19:0] ramp_div;
	logic signed [LEVEL_W-1:0] ramp_level;
	logic signed [LEVEL_W-1:0] level_d;
	logic signed [LEVEL_W-1:0] level_adj;

	// Load side of the divider
	assign diff     = $signed({5'b0, cfg.target_speed}) -
	                  $signed({encoder_count[11], encoder_count});
	assign diff_abs = diff[12] ? 13'(-diff) : 13'(diff);
	assign bat_dvs  = (cfg.battery_divisor == '0) ? DVS_W'(1) : cfg.battery_divisor;
	assign err_dvs  = (cfg.error_divisor == '0) ? DVS_W'(1) :
	                  {{(DVS_W-4){1'b0}}, cfg.error_divisor};

	// One restoring step per cycle
	assign rem_sh  = {rem_q, quo_q[DVD_W-1]};
	assign q_bit   = (rem_sh >= {1'b0, dvs_q});
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	// The battery quotient is in quo_q when the error division is loaded.
	assign comp_diff = $signed({7'b0, cfg.max_error}) - $signed({3'b0, quo_q});
	assign comp_prod = comp_diff * $signed({1'b0, cfg.battery_gain});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q      <= '0;
			quo_q      <= battery_level;
			dvs_q      <= bat_dvs;
			step_q     <= '0;
			diff_neg_q <= diff[12];
			diff_mag_q <= diff_abs[11:0];
		end else if (cmd.load_err) begin
			rem_q  <= '0;
			quo_q  <= {{(DVD_W-12){1'b0}}, diff_mag_q};
			dvs_q  <= err_dvs;
			step_q <= '0;
			prod_q <= comp_prod[23:0];
		end else if (cmd.step) begin
			rem_q  <= q_bit ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
			quo_q  <= {quo_q[DVD_W-2:0], q_bit};
			step_q <= step_q + STEP_W'(1);
		end
	end

	// Base level, truncated toward zero
	assign prod_adj = prod_q + (prod_q[23] ? 24'sd255 : 24'sd0);
	assign base     = prod_adj[23:8];

	// The error quotient is a magnitude; a negative error that truncates to
	// zero belongs to the zero band.
	assign err_neg  = diff_neg_q && (quo_q != '0);
	assign ramp_sel = !diff_neg_q && (quo_q > RAMP_THRESHOLD);

	always_comb begin
		if (err_neg) begin
			band_add = ADD_NEG;
		end else if (quo_q >= HIGH_THRESHOLD) begin
			band_add = ADD_HIGH;
		end else if (quo_q != '0) begin
			band_add = ADD_MID;
		end else begin
			band_add = ADD_ZERO;
		end
	end

	assign band_sum = $signed({base[15], base}) + $signed({10'b0, band_add});

	always_comb begin
		if (band_sum > DRIVE_MAX) begin
			band_clamp = 8'sd127;
		end else if (band_sum < -DRIVE_MAX) begin
			band_clamp = -8'sd127;
		end else begin
			band_clamp = band_sum[7:0];
		end
	end

	// Geometric ramp: the previous level plus one, times 1.2 in Q8.8
	assign ramp_in   = $signed({level_q[LEVEL_W-1], level_q}) + 18'sd256;
	assign ramp_prod = ramp_in * RAMP_GAIN_Q;
	assign ramp_adj  = ramp_prod + (ramp_prod[27] ? 28'sd255 : 28'sd0);
	assign ramp_div  = ramp_adj[27:8];

	always_comb begin
		if (ramp_div > 20'(DRIVE_MAX_Q)) begin
			ramp_level = DRIVE_MAX_Q;
		end else if (ramp_div < -20'(DRIVE_MAX_Q)) begin
			ramp_level = -DRIVE_MAX_Q;
		end else begin
			ramp_level = ramp_div[LEVEL_W-1:0];
		end
	end

	always_comb begin
		if (cfg.target_speed == '0) begin
			level_d = '0;
		end else if (ramp_sel) begin
			level_d = ramp_level;
		end else begin
			level_d = $signed({band_clamp[7], band_clamp, 8'b0});
		end
	end

	assign level_adj = level_d + (level_d[LEVEL_W-1] ? 17'sd255 : 17'sd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (cmd.update) begin
			level_q     <= level_d;
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			drive_q <= level_adj[15:8];
		end
	end

	assign sts.div_last = (step_q == STEP_W'(DIV_STEPS - 1));
	assign sts.out_free = !out_valid_q || !out_stall;
	assign out_valid    = out_valid_q;
	assign drive        = drive_q;

	// The remainder stays below the divisor; neither divisor can be zero.
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step || cmd.load_err) |=> (rem_q < dvs_q))
		else $error("divider remainder not below divisor");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		(level_q <= DRIVE_MAX_Q) && (level_q >= -DRIVE_MAX_Q))
		else $error("drive level out of range");

	a_update_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> (!out_valid_q || !out_stall))
		else $error("result written over one still waiting");

	a_update_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> out_valid_q)
		else $error("result not presented after update");

endmodule

// ===== hw/rtl/flywheel_speed_step_controller.sv =====
// Flywheel speed step controller: one request per control period in, one
// saturated motor drive out. The shared restoring divider runs the battery
// division and then the speed error division at one quotient bit per cycle,
// 14 quotient bits each; the ERR_LOAD state registers the compensated product
// between them, and the UPDATE state writes the drive once the output register
// is free. A new request is taken once the previous one has been written to
// the output register, even if that result still waits there.
// Configuration registers may be written only while no request is in flight.
// Depends on fssc_pkg, fssc_regs, fssc_ctrl and fssc_datapath.
module flywheel_speed_step_controller
	import fssc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic signed [11:0]     encoder_count,
	input  logic [13:0]            battery_level,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [7:0]      drive
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	fssc_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fssc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	fssc_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd           (cmd),
		.sts           (sts),
		.encoder_count (encoder_count),
		.battery_level (battery_level),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.drive         (drive)
	);

endmodule
